FILE: hdl/wss_pkg.sv
// Shared types, codes and defaults for the work-stealing task scheduler.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package wss_pkg;

    localparam int CORE_CNT_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_W          = 15;

    typedef logic [2:0] t_op;
    localparam t_op OP_SPAWN = 3'd0;
    localparam t_op OP_RUN   = 3'd1;
    localparam t_op OP_SLEEP = 3'd2;
    localparam t_op OP_SHUT  = 3'd3;
    localparam t_op OP_SIZE  = 3'd4;

    typedef logic [3:0] t_kind;
    localparam t_kind K_ASSIGNED    = 4'd0;
    localparam t_kind K_RUNNING     = 4'd1;
    localparam t_kind K_NO_RUN      = 4'd2;
    localparam t_kind K_MOVED       = 4'd3;
    localparam t_kind K_NONE_ASSIGN = 4'd4;
    localparam t_kind K_DELETED     = 4'd5;
    localparam t_kind K_NONE_REMOVE = 4'd6;
    localparam t_kind K_SIZE        = 4'd7;
    localparam t_kind K_FAIL        = 4'd8;
    localparam t_kind K_OVERFLOW    = 4'd9;

    // which core the datapath works on this cycle
    typedef logic [2:0] t_csel;
    localparam t_csel CS_ITEM       = 3'd0;
    localparam t_csel CS_LEAST_ALL  = 3'd1;
    localparam t_csel CS_LEAST_SKIP = 3'd2;
    localparam t_csel CS_MOST_SKIP  = 3'd3;
    localparam t_csel CS_SHUT       = 3'd4;

    // where a result takes its task field from
    typedef logic [1:0] t_tsel;
    localparam t_tsel TS_ZERO = 2'd0;
    localparam t_tsel TS_ITEM = 2'd1;
    localparam t_tsel TS_RD   = 2'd2;

    typedef struct packed {
        logic  latch;
        t_csel core_sel;
        logic  rd_front;
        logic  rd_back;
        logic  push;
        logic  push_src_rd;
        logic  emit;
        t_kind kind;
        logic  emit_core;
        t_tsel emit_task;
        logic  emit_cnt;
        logic  last;
        logic  shut_inc;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic item_valid;
        logic task_ok;
        logic item_empty;
        logic sel_empty;
        logic sel_full;
        logic shut_done;
        logic shut_tail_empty;
        logic shut_any;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/wss_item_if.sv
// Request channel: valid/ready handshake with the operation fields.
// Stands alone; widths follow the request format.
`default_nettype none
interface wss_item_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [2:0]        core_index;
    logic signed [15:0] task_id;

    modport source (output valid, output operation, output core_index, output task_id,
                    input ready);
    modport sink   (input valid, input operation, input core_index, input task_id,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/wss_res_if.sv
// Result channel: valid/ready handshake with the result fields.
// Stands alone; widths follow the result format.
`default_nettype none
interface wss_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [1:0]  core_id;
    logic [14:0] task_res;
    logic [4:0]  count;
    logic        last;

    modport source (output valid, output kind, output core_id, output task_res,
                    output count, output last, input ready);
    modport sink   (input valid, input kind, input core_id, input task_res,
                    input count, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/wss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/wss_ctl.sv
// Controller state machine: sequences each request into datapath commands.
// Depends on wss_pkg (t_cmd, t_sts, codes).
`default_nettype none
module wss_ctl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire wss_pkg::t_sts i_sts,
    output wss_pkg::t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_RUN_EM = 4'd2;
    localparam logic [3:0] S_ST_RD  = 4'd3;
    localparam logic [3:0] S_ST_WR  = 4'd4;
    localparam logic [3:0] S_SL_RD  = 4'd5;
    localparam logic [3:0] S_SL_EM  = 4'd6;
    localparam logic [3:0] S_SH_CHK = 4'd7;
    localparam logic [3:0] S_SH_EM  = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.core_sel = (i_sts.op == wss_pkg::OP_SPAWN) ? wss_pkg::CS_LEAST_ALL
                                                                  : wss_pkg::CS_ITEM;
                o_cmd.last     = 1'b1;
                o_cmd.kind     = wss_pkg::K_FAIL;
                case (i_sts.op)
                    wss_pkg::OP_SPAWN: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                            if (i_sts.task_ok) begin
                                o_cmd.emit_core = 1'b1;
                                o_cmd.emit_task = wss_pkg::TS_ITEM;
                                if (i_sts.sel_full) begin
                                    o_cmd.kind = wss_pkg::K_OVERFLOW;
                                end else begin
                                    o_cmd.kind = wss_pkg::K_ASSIGNED;
                                    o_cmd.push = 1'b1;
                                end
                            end
                        end
                    end
                    wss_pkg::OP_RUN: begin
                        if (!i_sts.item_valid) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else if (i_sts.sel_empty) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.kind      = wss_pkg::K_NO_RUN;
                                o_cmd.emit_core = 1'b1;
                                n_state         = S_ST_RD;
                            end
                        end else begin
                            o_cmd.rd_front = 1'b1;
                            n_state        = S_RUN_EM;
                        end
                    end
                    wss_pkg::OP_SLEEP: begin
                        if (!i_sts.item_valid) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else if (i_sts.sel_empty) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.kind      = wss_pkg::K_NONE_ASSIGN;
                                o_cmd.emit_core = 1'b1;
                                n_state         = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_back = 1'b1;
                            n_state       = S_SL_EM;
                        end
                    end
                    wss_pkg::OP_SHUT: begin
                        n_state = S_SH_CHK;
                    end
                    wss_pkg::OP_SIZE: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                            if (i_sts.item_valid) begin
                                o_cmd.kind      = wss_pkg::K_SIZE;
                                o_cmd.emit_core = 1'b1;
                                o_cmd.emit_cnt  = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_RUN_EM: begin
                o_cmd.core_sel = wss_pkg::CS_ITEM;
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = wss_pkg::K_RUNNING;
                    o_cmd.emit_core = 1'b1;
                    o_cmd.emit_task = wss_pkg::TS_RD;
                    o_cmd.last      = 1'b1;
                    n_state         = i_sts.sel_empty ? S_ST_RD : S_IDLE;
                end
            end
            S_ST_RD: begin
                // take the back task of the fullest other core, if any
                o_cmd.core_sel = wss_pkg::CS_MOST_SKIP;
                if (i_sts.sel_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd_back = 1'b1;
                    n_state       = S_ST_WR;
                end
            end
            S_ST_WR: begin
                o_cmd.core_sel    = wss_pkg::CS_ITEM;
                o_cmd.push        = 1'b1;
                o_cmd.push_src_rd = 1'b1;
                n_state           = S_IDLE;
            end
            S_SL_RD: begin
                o_cmd.core_sel = wss_pkg::CS_ITEM;
                o_cmd.rd_back  = 1'b1;
                n_state        = S_SL_EM;
            end
            S_SL_EM: begin
                o_cmd.core_sel = wss_pkg::CS_LEAST_SKIP;
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_core   = 1'b1;
                    o_cmd.emit_task   = wss_pkg::TS_RD;
                    o_cmd.last        = i_sts.item_empty;
                    o_cmd.push_src_rd = 1'b1;
                    if (i_sts.sel_full) begin
                        o_cmd.kind = wss_pkg::K_OVERFLOW;
                    end else begin
                        o_cmd.kind = wss_pkg::K_MOVED;
                        o_cmd.push = 1'b1;
                    end
                    n_state = i_sts.item_empty ? S_IDLE : S_SL_RD;
                end
            end
            S_SH_CHK: begin
                o_cmd.core_sel = wss_pkg::CS_SHUT;
                if (i_sts.shut_done) begin
                    if (i_sts.shut_any) begin
                        n_state = S_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = wss_pkg::K_NONE_REMOVE;
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_sts.sel_empty) begin
                    o_cmd.shut_inc = 1'b1;
                end else begin
                    o_cmd.rd_front = 1'b1;
                    n_state        = S_SH_EM;
                end
            end
            S_SH_EM: begin
                o_cmd.core_sel = wss_pkg::CS_SHUT;
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = wss_pkg::K_DELETED;
                    o_cmd.emit_core = 1'b1;
                    o_cmd.emit_task = wss_pkg::TS_RD;
                    o_cmd.last      = i_sts.shut_tail_empty;
                    n_state         = S_SH_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hdl/wss_dp.sv
// Datapath: request latch, per-core deque pointers, load scan, task RAM,
// result register. Depends on wss_pkg and wss_ram.
`default_nettype none
module wss_dp #(
    parameter int CORE_CNT    = wss_pkg::CORE_CNT_DEF,
    parameter int QUEUE_DEPTH = wss_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [2:0]         i_active,
    input  wire logic [2:0]         i_operation,
    input  wire logic [2:0]         i_core_index,
    input  wire logic signed [15:0] i_task_id,
    input  wire wss_pkg::t_cmd      i_cmd,
    output wss_pkg::t_sts           o_sts,
    input  wire logic               i_res_ready,
    output logic                    o_res_valid,
    output logic [3:0]              o_kind,
    output logic [1:0]              o_core_id,
    output logic [14:0]             o_task_res,
    output logic [4:0]              o_count,
    output logic                    o_last
);
    localparam int CW    = (CORE_CNT > 2) ? $clog2(CORE_CNT) : 1;
    localparam int HW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int PW    = FW + 1;
    localparam int SW    = $clog2(CORE_CNT + 1);
    localparam int DEPTH = CORE_CNT * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = wss_pkg::TASK_W;

    logic [2:0]     r_op;
    logic [2:0]     r_core;
    logic [15:0]    r_task;
    logic [HW-1:0]  r_head [CORE_CNT];
    logic [FW-1:0]  r_fill [CORE_CNT];
    logic [SW-1:0]  r_idx;
    logic           r_any;
    logic           r_ov;
    logic [3:0]     r_kind;
    logic [1:0]     r_cid;
    logic [TW-1:0]  r_tres;
    logic [4:0]     r_cnt;
    logic           r_last;

    logic [SW-1:0]  w_n;
    logic [CW-1:0]  w_item, w_least, w_most, w_sel;
    logic [FW-1:0]  w_lv, w_mv, w_sel_fill, w_item_fill;
    logic [HW-1:0]  w_sel_head;
    logic           w_lfound, w_mfound, w_skip_l, w_valid, w_tail_empty, w_out_free;
    logic [PW-1:0]  w_sum_push, w_sum_back;
    logic [HW-1:0]  w_pos_push, w_pos_back;
    logic [AW-1:0]  w_base, w_raddr, w_waddr;
    logic [TW-1:0]  w_rdata, w_wdata;

    // saturate the active core count to the supported range
    always_comb begin
        if (i_active < 3'd2) begin
            w_n = SW'(2);
        end else if (int'(i_active) > CORE_CNT) begin
            w_n = SW'(CORE_CNT);
        end else begin
            w_n = SW'(i_active);
        end
    end

    assign w_item  = r_core[CW-1:0];
    assign w_valid = (4'(r_core) < 4'(w_n));
    assign w_skip_l = (i_cmd.core_sel == wss_pkg::CS_LEAST_SKIP);

    // least- and most-loaded scan, lowest index wins ties
    always_comb begin
        w_least  = '0;
        w_most   = '0;
        w_lv     = '0;
        w_mv     = '0;
        w_lfound = 1'b0;
        w_mfound = 1'b0;
        for (int i = 0; i < CORE_CNT; i++) begin
            if (SW'(i) < w_n) begin
                if (!(w_skip_l && CW'(i) == w_item)) begin
                    if (!w_lfound || r_fill[i] < w_lv) begin
                        w_least  = CW'(i);
                        w_lv     = r_fill[i];
                        w_lfound = 1'b1;
                    end
                end
                if (CW'(i) != w_item) begin
                    if (!w_mfound || r_fill[i] > w_mv) begin
                        w_most   = CW'(i);
                        w_mv     = r_fill[i];
                        w_mfound = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        case (i_cmd.core_sel)
            wss_pkg::CS_ITEM:       w_sel = w_item;
            wss_pkg::CS_LEAST_ALL:  w_sel = w_least;
            wss_pkg::CS_LEAST_SKIP: w_sel = w_least;
            wss_pkg::CS_MOST_SKIP:  w_sel = w_most;
            wss_pkg::CS_SHUT:       w_sel = r_idx[CW-1:0];
            default:                w_sel = '0;
        endcase
    end

    always_comb begin
        w_sel_fill   = '0;
        w_sel_head   = '0;
        w_item_fill  = '0;
        w_tail_empty = 1'b1;
        for (int i = 0; i < CORE_CNT; i++) begin
            if (CW'(i) == w_sel) begin
                w_sel_fill = r_fill[i];
                w_sel_head = r_head[i];
            end
            if (CW'(i) == w_item) begin
                w_item_fill = r_fill[i];
            end
            if (SW'(i) >= r_idx && SW'(i) < w_n && r_fill[i] != '0) begin
                w_tail_empty = 1'b0;
            end
        end
    end

    // ring positions, wrapped with one compare and subtract
    assign w_sum_push = PW'(w_sel_head) + PW'(w_sel_fill);
    assign w_sum_back = w_sum_push - PW'(1);
    assign w_pos_push = (w_sum_push >= PW'(QUEUE_DEPTH)) ?
                        HW'(w_sum_push - PW'(QUEUE_DEPTH)) : HW'(w_sum_push);
    assign w_pos_back = (w_sum_back >= PW'(QUEUE_DEPTH)) ?
                        HW'(w_sum_back - PW'(QUEUE_DEPTH)) : HW'(w_sum_back);
    assign w_base     = AW'(int'(w_sel) * QUEUE_DEPTH);
    assign w_raddr    = w_base + AW'(i_cmd.rd_front ? w_sel_head : w_pos_back);
    assign w_waddr    = w_base + AW'(w_pos_push);
    assign w_wdata    = i_cmd.push_src_rd ? w_rdata : r_task[TW-1:0];

    wss_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_front | i_cmd.rd_back),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_operation;
            r_core <= i_core_index;
            r_task <= i_task_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CORE_CNT; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            for (int i = 0; i < CORE_CNT; i++) begin
                if (CW'(i) == w_sel) begin
                    if (i_cmd.rd_front) begin
                        r_head[i] <= (r_head[i] == HW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_head[i] + HW'(1);
                        r_fill[i] <= r_fill[i] - FW'(1);
                    end else if (i_cmd.rd_back) begin
                        r_fill[i] <= r_fill[i] - FW'(1);
                    end else if (i_cmd.push) begin
                        r_fill[i] <= r_fill[i] + FW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_any <= 1'b0;
        end else if (i_cmd.latch) begin
            r_idx <= '0;
            r_any <= 1'b0;
        end else begin
            if (i_cmd.shut_inc) begin
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.emit && i_cmd.kind == wss_pkg::K_DELETED) begin
                r_any <= 1'b1;
            end
        end
    end

    assign w_out_free = !r_ov || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= i_cmd.kind;
            r_cid  <= i_cmd.emit_core ? 2'(w_sel) : 2'd0;
            r_cnt  <= i_cmd.emit_cnt ? 5'(w_sel_fill) : 5'd0;
            r_last <= i_cmd.last;
            case (i_cmd.emit_task)
                wss_pkg::TS_ITEM: r_tres <= r_task[TW-1:0];
                wss_pkg::TS_RD:   r_tres <= w_rdata;
                default:          r_tres <= '0;
            endcase
        end
    end

    assign o_res_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_core_id   = r_cid;
    assign o_task_res  = r_tres;
    assign o_count     = r_cnt;
    assign o_last      = r_last;

    always_comb begin
        o_sts                 = '0;
        o_sts.op              = r_op;
        o_sts.item_valid      = w_valid;
        o_sts.task_ok         = (r_task != 16'd0) && !r_task[15];
        o_sts.item_empty      = (w_item_fill == '0);
        o_sts.sel_empty       = (w_sel_fill == '0);
        o_sts.sel_full        = (w_sel_fill == FW'(QUEUE_DEPTH));
        o_sts.shut_done       = (r_idx >= w_n);
        o_sts.shut_tail_empty = w_tail_empty;
        o_sts.shut_any        = r_any;
        o_sts.out_free        = w_out_free;
    end
endmodule
`default_nettype wire

FILE: hdl/work_stealing_task_scheduler_core.sv
// Top level of the work-stealing task scheduler: configuration register,
// controller and datapath. Depends on wss_pkg, wss_item_if, wss_res_if, wss_ctl, wss_dp.
//
//  channel   direction  handshake               payload
//  i_item    in         valid/ready             operation, core_index, task_id
//  o_res     out        valid/ready             kind, core_id, task_res, count, last
//  apb       in         psel/penable, pready=1  active_cores at address 0
//
// One request at a time. Sleep moves its tasks one by one; shutdown visits each active
// core in turn and deletes its tasks one by one; the single RAM port pair and the
// deque pointer update set this pace.
// The result register holds a result until taken; a stalled output holds the
// controller in its current step. Synchronous active-low reset empties all deques.
`default_nettype none
module work_stealing_task_scheduler_core #(
    parameter int CORE_CNT    = wss_pkg::CORE_CNT_DEF,
    parameter int QUEUE_DEPTH = wss_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wss_item_if.sink    i_item,
    wss_res_if.source   o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic [2:0]    r_active;
    wss_pkg::t_cmd w_cmd;
    wss_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {29'd0, r_active} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 3'd4;
        end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
            r_active <= pwdata[2:0];
        end
    end

    wss_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    wss_dp #(.CORE_CNT(CORE_CNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_active     (r_active),
        .i_operation  (i_item.operation),
        .i_core_index (i_item.core_index),
        .i_task_id    (i_item.task_id),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_kind       (o_res.kind),
        .o_core_id    (o_res.core_id),
        .o_task_res   (o_res.task_res),
        .o_count      (o_res.count),
        .o_last       (o_res.last)
    );
endmodule
`default_nettype wire

FILE: hdl/wss_chk.sv
// Port-level checks for the scheduler core, bound to the top level.
// Depends on wss_pkg and work_stealing_task_scheduler_core.
`default_nettype none
module wss_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  i_kind,
    input wire logic [1:0]  i_core_id,
    input wire logic [14:0] i_task_res,
    input wire logic        i_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_last))
        else $error("result dropped or changed while stalled");

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while previous one in progress");

    a_size_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == wss_pkg::K_SIZE |-> i_last)
        else $error("size result not final");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == wss_pkg::K_FAIL |->
            i_core_id == 2'd0 && i_task_res == 15'd0 && i_last)
        else $error("failure result malformed");
endmodule

bind work_stealing_task_scheduler_core wss_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_core_id   (o_res.core_id),
    .i_task_res  (o_res.task_res),
    .i_last      (o_res.last)
);
`default_nettype wire

FILE: tb/work_stealing_task_scheduler_core_tb.sv
// Randomized self-checking testbench for the work-stealing task scheduler core.
// Depends on wss_pkg, wss_item_if, wss_res_if and work_stealing_task_scheduler_core.
`default_nettype none

class sched_scoreboard;
    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  core_id;
        logic [14:0] task_res;
        logic [4:0]  count;
        logic        last;
    } t_result;

    logic [14:0] deque_mem[4][16];
    int unsigned head[4];
    int unsigned fill[4];
    int unsigned active_cfg;
    t_result     pending[$];
    int          errors;

    function new();
        for (int c = 0; c < 4; c++) begin
            head[c] = 0;
            fill[c] = 0;
        end
        active_cfg = 4;
        errors     = 0;
    endfunction

    function int unsigned cores_used();
        if (active_cfg < 2) return 2;
        if (active_cfg > 4) return 4;
        return active_cfg;
    endfunction

    // skip >= 4 means no core is excluded
    function int unsigned least_loaded(int unsigned skip);
        int unsigned best;
        best = 4;
        for (int unsigned i = 0; i < cores_used(); i++) begin
            if (i == skip) continue;
            if (best == 4 || fill[i] < fill[best]) best = i;
        end
        return best;
    endfunction

    function int unsigned most_loaded(int unsigned skip);
        int unsigned best;
        best = 4;
        for (int unsigned i = 0; i < cores_used(); i++) begin
            if (i == skip) continue;
            if (best == 4 || fill[i] > fill[best]) best = i;
        end
        return best;
    endfunction

    function bit push_back(int unsigned c, logic [14:0] t);
        if (fill[c] >= 16) return 0;
        deque_mem[c][(head[c] + fill[c]) % 16] = t;
        fill[c]++;
        return 1;
    endfunction

    function logic [14:0] take_front(int unsigned c);
        logic [14:0] t;
        t       = deque_mem[c][head[c]];
        head[c] = (head[c] + 1) % 16;
        fill[c]--;
        return t;
    endfunction

    function logic [14:0] take_back(int unsigned c);
        fill[c]--;
        return deque_mem[c][(head[c] + fill[c]) % 16];
    endfunction

    function void steal_into(int unsigned c);
        int unsigned src;
        bit          ok;
        src = most_loaded(c);
        if (src < 4 && fill[src] != 0) ok = push_back(c, take_back(src));
    endfunction

    function void add(logic [3:0] k, int unsigned c, logic [14:0] t, int unsigned n);
        t_result r;
        r.kind     = k;
        r.core_id  = c[1:0];
        r.task_res = t;
        r.count    = n[4:0];
        r.last     = 0;
        pending.push_back(r);
    endfunction

    function void note_request(logic [2:0] op, logic [2:0] core, logic signed [15:0] tid);
        int unsigned before_n, dst, c;
        bit          valid;
        logic [14:0] t;
        before_n = pending.size();
        c        = core;
        valid    = c < cores_used();
        case (op)
            wss_pkg::OP_SPAWN: begin
                if (tid <= 0) add(wss_pkg::K_FAIL, 0, 0, 0);
                else begin
                    dst = least_loaded(4);
                    add(push_back(dst, tid[14:0]) ? wss_pkg::K_ASSIGNED : wss_pkg::K_OVERFLOW,
                        dst, tid[14:0], 0);
                end
            end
            wss_pkg::OP_RUN: begin
                if (!valid) add(wss_pkg::K_FAIL, 0, 0, 0);
                else if (fill[c] == 0) begin
                    add(wss_pkg::K_NO_RUN, c, 0, 0);
                    steal_into(c);
                end else begin
                    add(wss_pkg::K_RUNNING, c, take_front(c), 0);
                    if (fill[c] == 0) steal_into(c);
                end
            end
            wss_pkg::OP_SLEEP: begin
                if (!valid) add(wss_pkg::K_FAIL, 0, 0, 0);
                else if (fill[c] == 0) add(wss_pkg::K_NONE_ASSIGN, c, 0, 0);
                else while (fill[c] > 0) begin
                    t   = take_back(c);
                    dst = least_loaded(c);
                    add(push_back(dst, t) ? wss_pkg::K_MOVED : wss_pkg::K_OVERFLOW, dst, t, 0);
                end
            end
            wss_pkg::OP_SHUT: begin
                for (int unsigned i = 0; i < cores_used(); i++)
                    while (fill[i] > 0) add(wss_pkg::K_DELETED, i, take_front(i), 0);
                if (pending.size() == before_n) add(wss_pkg::K_NONE_REMOVE, 0, 0, 0);
            end
            wss_pkg::OP_SIZE: begin
                if (!valid) add(wss_pkg::K_FAIL, 0, 0, 0);
                else add(wss_pkg::K_SIZE, c, 0, fill[c]);
            end
            default: add(wss_pkg::K_FAIL, 0, 0, 0);
        endcase
        pending[pending.size() - 1].last = 1;
    endfunction

    function void check_result(t_result got);
        t_result exp;
        if (pending.size() == 0) begin
            $error("unexpected result kind=%0d core=%0d task=%0d", got.kind, got.core_id,
                   got.task_res);
            errors++;
            return;
        end
        exp = pending[0];
        pending.delete(0);
        if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, got %0d", exp.kind, got.kind); errors++;
        end
        if (got.core_id !== exp.core_id) begin
            $error("core_id: expected %0d, got %0d", exp.core_id, got.core_id); errors++;
        end
        if (got.task_res !== exp.task_res) begin
            $error("task_res: expected %0d, got %0d", exp.task_res, got.task_res); errors++;
        end
        if (got.count !== exp.count) begin
            $error("count: expected %0d, got %0d", exp.count, got.count); errors++;
        end
        if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
        end
    endfunction
endclass

module work_stealing_task_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    bit          calm;        // no idling in the last part of the run

    wss_item_if req_ch();
    wss_res_if  res_ch();

    sched_scoreboard board;

    work_stealing_task_scheduler_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (req_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #20ms;
        $display("work_stealing_task_scheduler_core_tb: done, errors");
        $finish;
    end

    // result sink with bursty stalls
    initial begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        stall        = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                board.check_result({res_ch.kind, res_ch.core_id, res_ch.task_res,
                                    res_ch.count, res_ch.last});
            if (stall > 0) stall--;
            else if (!calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 18);
            res_ch.ready <= (stall == 0);
        end
    end

    task automatic write_active(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.active_cfg = value & 32'h7;
    endtask

    // wait until every expected result is in, then let the core settle
    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_request(logic [2:0] op, logic [2:0] core, logic signed [15:0] tid);
        if (!calm && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.core_index <= core;
        req_ch.task_id    <= tid;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(op, core, tid);
        req_ch.valid <= 1'b0;
        // the core is busy on the cycle after a request
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_task();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);                  // any value, sign bit too
            1:       return 16'sh7fff;
            default: return 16'($urandom_range(1, 32767));
        endcase
    endfunction

    task automatic random_phase(int unsigned n);
        int unsigned sel;
        for (int unsigned k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_request(wss_pkg::OP_SPAWN, 3'($urandom), rand_task());
            else if (sel < 75)
                send_request(wss_pkg::OP_RUN, 3'($urandom_range(0, 4)), 16'($urandom));
            else if (sel < 83)
                send_request(wss_pkg::OP_SLEEP, 3'($urandom_range(0, 4)), 16'($urandom));
            else if (sel < 86)
                send_request(wss_pkg::OP_SHUT, 3'($urandom), 16'($urandom));
            else if (sel < 96)
                send_request(wss_pkg::OP_SIZE, 3'($urandom), 16'($urandom));
            else
                send_request(3'($urandom_range(5, 7)), 3'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        board             = new();
        calm              = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = '0;
        req_ch.core_index = '0;
        req_ch.task_id    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_active(4);
        // directed: empty-state cases, bad tasks, bad cores, unknown codes
        send_request(wss_pkg::OP_SHUT, 0, 0);
        send_request(wss_pkg::OP_RUN, 0, 0);
        send_request(wss_pkg::OP_SLEEP, 1, 0);
        send_request(wss_pkg::OP_SPAWN, 0, 0);
        send_request(wss_pkg::OP_SPAWN, 0, 16'sh8000);
        send_request(wss_pkg::OP_SPAWN, 0, -16'sd1);
        send_request(wss_pkg::OP_RUN, 7, 0);
        send_request(wss_pkg::OP_SIZE, 4, 0);
        send_request(3'd5, 0, 0);
        send_request(3'd7, 7, 16'sh7fff);
        send_request(wss_pkg::OP_SPAWN, 7, 16'sh7fff);
        send_request(wss_pkg::OP_SPAWN, 0, 16'sd1);
        send_request(wss_pkg::OP_SPAWN, 0, 16'sh5555);
        send_request(wss_pkg::OP_RUN, 3, 0);          // empty core steals
        send_request(wss_pkg::OP_RUN, 0, 0);          // emptied by the steal, steals too
        send_request(wss_pkg::OP_SLEEP, 0, 0);
        send_request(wss_pkg::OP_SIZE, 3, 0);
        send_request(wss_pkg::OP_SHUT, 0, 0);
        drain();

        // fill both active deques to overflow, then sleep onto the full other core
        write_active(2);
        for (int k = 0; k < 34; k++)
            send_request(wss_pkg::OP_SPAWN, 0, 16'($urandom_range(1, 32767)));
        send_request(wss_pkg::OP_SLEEP, 1, 0);
        send_request(wss_pkg::OP_SIZE, 0, 0);
        send_request(wss_pkg::OP_SIZE, 2, 0);
        send_request(wss_pkg::OP_SHUT, 0, 0);
        drain();

        // out-of-range settings saturate
        write_active(0);
        random_phase(40);
        drain();
        write_active(7);
        random_phase(60);
        drain();
        write_active(3);
        random_phase(100);
        drain();
        write_active(1);
        random_phase(40);
        drain();
        write_active(4);
        random_phase(64);
        calm = 1'b1;
        random_phase(60);

        drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        if (board.errors == 0)
            $display("work_stealing_task_scheduler_core_tb: done, clean");
        else
            $display("work_stealing_task_scheduler_core_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
